[hw/rtl/fspc_pkg.sv]
// Shared types, register codes and constants of the frame stack pixel combiner.
package fspc_pkg;

    // Number of frame sample ports on the block.
    localparam int NUM_PORTS = 8;

    // Width of a lane's rank among the active lanes.
    localparam int RANK_W = 3;

    // Width of the frame count register.
    localparam int FRAMES_W = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

    // Combine mode codes. The unused code behaves as median.
    localparam logic [1:0] MODE_SUM    = 2'd0;
    localparam logic [1:0] MODE_MEAN   = 2'd1;
    localparam logic [1:0] MODE_MEDIAN = 2'd2;

    // Result format.
    localparam int OUT_W = 20;
    localparam logic [OUT_W-1:0] OUT_MAX = 20'hFFFFF;

    // Mean divider: operands below 2^23 times a 24-bit reciprocal, shift by 23.
    localparam int DIV_X_W   = 23;
    localparam int RECIP_W   = 24;
    localparam int DIV_CMP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP_1 = 24'((1 << 23) / 1);
    localparam logic [RECIP_W-1:0] RECIP_2 = 24'((1 << 23) / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = 24'((1 << 23) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = 24'((1 << 23) / 4);
    localparam logic [RECIP_W-1:0] RECIP_5 = 24'((1 << 23) / 5);
    localparam logic [RECIP_W-1:0] RECIP_6 = 24'((1 << 23) / 6);
    localparam logic [RECIP_W-1:0] RECIP_7 = 24'((1 << 23) / 7);
    localparam logic [RECIP_W-1:0] RECIP_8 = 24'((1 << 23) / 8);

    // Control fields that travel with a pixel down the pipeline.
    typedef struct packed {
        logic [FRAMES_W-1:0] frames;
        logic [1:0]          mode;
        logic                last;
    } t_side;

    // Width of twice the sum of n samples of sw bits.
    function automatic int f_x_w(input int n, input int sw);
        return sw + $clog2(n) + 1;
    endfunction

    // Reciprocal of the frame count, scaled by 2^23 and rounded down.
    function automatic logic [RECIP_W-1:0] f_recip(input logic [FRAMES_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd1: r = RECIP_1;
            4'd2: r = RECIP_2;
            4'd3: r = RECIP_3;
            4'd4: r = RECIP_4;
            4'd5: r = RECIP_5;
            4'd6: r = RECIP_6;
            4'd7: r = RECIP_7;
            4'd8: r = RECIP_8;
            default: r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/fspc_lane.sv]
// One frame lane: masks its sample and finds its rank among the active lanes.
module fspc_lane #(
    parameter int N    = 8,
    parameter int SW   = 16,
    parameter int LANE = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [SW-1:0]                 i_samples [fspc_pkg::NUM_PORTS],
    input  logic [fspc_pkg::FRAMES_W-1:0] i_frames,
    output logic [SW-1:0]                 o_value,
    output logic [fspc_pkg::RANK_W-1:0]   o_rank,
    output logic                          o_used
);

    logic [SW-1:0]               w_me;
    logic [fspc_pkg::RANK_W-1:0] n_rank;
    logic                        n_used;
    logic [SW-1:0]               r_value;
    logic [fspc_pkg::RANK_W-1:0] r_rank;
    logic                        r_used;

    // Ties are broken by lane order, so active lanes get distinct ranks.
    always_comb begin
        w_me   = i_samples[LANE];
        n_used = fspc_pkg::FRAMES_W'(LANE) < i_frames;
        n_rank = '0;
        for (int j = 0; j < N; j++) begin
            if (j != LANE) begin
                n_rank = n_rank + fspc_pkg::RANK_W'(
                    (fspc_pkg::FRAMES_W'(j) < i_frames) &&
                    ((i_samples[j] < w_me) || ((i_samples[j] == w_me) && (j < LANE))));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_used ? w_me : '0;
            r_rank  <= n_rank;
            r_used  <= n_used;
        end
    end

    assign o_value = r_value;
    assign o_rank  = r_rank;
    assign o_used  = r_used;

endmodule

[hw/rtl/fspc_merge.sv]
// Merge stage: sums the lanes and picks the middle values by rank.
module fspc_merge #(
    parameter int N  = 8,
    parameter int SW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [SW-1:0]               i_value [N],
    input  logic [fspc_pkg::RANK_W-1:0] i_rank  [N],
    input  logic                        i_used  [N],
    input  fspc_pkg::t_side             i_side,
    output logic [fspc_pkg::f_x_w(N, SW)-1:0] o_x,
    output logic [SW:0]                 o_med,
    output fspc_pkg::t_side             o_side
);

    localparam int XW   = fspc_pkg::f_x_w(N, SW);
    localparam int SUMW = XW - 1;

    logic [fspc_pkg::RANK_W-1:0] w_m_hi;
    logic [fspc_pkg::RANK_W-1:0] w_m_lo;
    logic [SUMW-1:0]             w_sum;
    logic [SW-1:0]               w_lo_val;
    logic [SW-1:0]               w_hi_val;
    logic [N-1:0]                w_hit_lo;
    logic [N-1:0]                w_hit_hi;
    logic [XW-1:0]               r_x;
    logic [SW:0]                 r_med;
    fspc_pkg::t_side             r_side;

    // For an odd count both middle ranks are the same lane, so lo + hi is twice it.
    always_comb begin
        w_m_hi   = fspc_pkg::RANK_W'(i_side.frames >> 1);
        w_m_lo   = i_side.frames[0] ? w_m_hi : w_m_hi - fspc_pkg::RANK_W'(1);
        w_sum    = '0;
        w_lo_val = '0;
        w_hi_val = '0;
        for (int i = 0; i < N; i++) begin
            w_sum       = w_sum + SUMW'(i_value[i]);
            w_hit_lo[i] = i_used[i] && (i_rank[i] == w_m_lo);
            w_hit_hi[i] = i_used[i] && (i_rank[i] == w_m_hi);
            if (w_hit_lo[i]) begin
                w_lo_val = w_lo_val | i_value[i];
            end
            if (w_hit_hi[i]) begin
                w_hi_val = w_hi_val | i_value[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= {w_sum, 1'b0};
            r_med  <= {1'b0, w_lo_val} + {1'b0, w_hi_val};
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_med  = r_med;
    assign o_side = r_side;

`ifndef ASSERT_OFF
    // Exactly one active lane holds each middle rank.
    a_one_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ($countones(w_hit_lo) == 1) && ($countones(w_hit_hi) == 1))
        else $error("middle rank not held by exactly one lane");
`endif

endmodule

[hw/rtl/fspc_finish.sv]
// Final stages: mean by reciprocal multiply, saturation and result select.
module fspc_finish #(
    parameter int N  = 8,
    parameter int SW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en3,
    input  logic                              i_en4,
    input  logic                              i_s3_valid,
    input  logic [fspc_pkg::f_x_w(N, SW)-1:0] i_x,
    input  logic [SW:0]                       i_med,
    input  fspc_pkg::t_side                   i_side,
    output logic [fspc_pkg::OUT_W-1:0]        o_result,
    output logic                              o_last
);

    localparam int XW = fspc_pkg::f_x_w(N, SW);
    localparam int CW = (XW > fspc_pkg::DIV_CMP_W) ? XW : fspc_pkg::DIV_CMP_W;
    localparam int DW = fspc_pkg::DIV_X_W;
    localparam int OW = fspc_pkg::OUT_W;
    localparam int PW = DW + fspc_pkg::RECIP_W;

    logic [CW-1:0]   w_x_ext;
    logic [CW-1:0]   w_med_ext;
    logic [CW-1:0]   w_limit;
    logic [CW-1:0]   w_vmax;
    logic [PW-1:0]   w_prod;
    logic [OW-1:0]   n_alt;
    logic [OW+fspc_pkg::FRAMES_W-1:0] w_qk;
    logic [DW-1:0]   w_rem;
    logic [OW-1:0]   w_q;
    logic [OW-1:0]   n_result;

    logic [OW-1:0]   r_q0;
    logic [DW-1:0]   r_x23;
    logic            r_sat;
    logic [OW-1:0]   r_alt;
    fspc_pkg::t_side r_side;
    logic [OW-1:0]   r_result;
    logic            r_last;

    // Stage 3: a mean is saturated when 2*sum reaches k * 2^20; otherwise the
    // operand fits 23 bits and the scaled reciprocal gives the quotient or one less.
    always_comb begin
        w_x_ext   = CW'(i_x);
        w_med_ext = CW'(i_med);
        w_vmax    = CW'(fspc_pkg::OUT_MAX);
        w_limit   = CW'({i_side.frames, {OW{1'b0}}});
        w_prod    = w_x_ext[DW-1:0] * fspc_pkg::f_recip(i_side.frames);
        case (i_side.mode)
            fspc_pkg::MODE_SUM:
                n_alt = (w_x_ext > w_vmax) ? fspc_pkg::OUT_MAX : w_x_ext[OW-1:0];
            default:
                n_alt = (w_med_ext > w_vmax) ? fspc_pkg::OUT_MAX : w_med_ext[OW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_q0   <= w_prod[DW+OW-1:DW];
            r_x23  <= w_x_ext[DW-1:0];
            r_sat  <= w_x_ext >= w_limit;
            r_alt  <= n_alt;
            r_side <= i_side;
        end
    end

    // Stage 4: one correction step on the quotient estimate.
    always_comb begin
        w_qk  = r_q0 * r_side.frames;
        w_rem = r_x23 - DW'(w_qk);
        w_q   = r_q0 + OW'(w_rem >= DW'(r_side.frames));
        case (r_side.mode)
            fspc_pkg::MODE_MEAN: n_result = r_sat ? fspc_pkg::OUT_MAX : w_q;
            default:             n_result = r_alt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_result <= n_result;
            r_last   <= r_side.last;
        end
    end

    assign o_result = r_result;
    assign o_last   = r_last;

`ifndef ASSERT_OFF
    // The reciprocal estimate is never more than one below the true quotient.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s3_valid && !r_sat) |->
            ({1'b0, w_rem} < (DW + 1)'({r_side.frames, 1'b0})))
        else $error("mean quotient estimate off by more than one");
`endif

endmodule

[hw/rtl/frame_stack_pixel_combine_core.sv]
// Top level of the frame stack pixel combiner: configuration, lanes and pipeline control.
//
// Each input transfer carries one pixel position's samples from up to eight aligned
// frames plus an end-of-image mark. The first frames_in_use lanes are combined by sum,
// mean or median and one result transfer leaves per input transfer, in order, as the
// combined value times two (one fractional bit), saturated at 20 bits.
//
// Channels: input (i_in_valid / o_in_ready), output (o_out_valid / i_out_ready) and a
// configuration write channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) that
// is always ready. Index 0 is combine_mode, index 1 is frames_in_use. Write it only when
// no pixel is in flight.
//
// Each pixel passes four registered stages before its result is valid. Throughput is
// one pixel per cycle while the output is not stalled: the lanes rank all samples in
// parallel in one stage, the merge stage sums and picks the middle values, and the mean
// uses a reciprocal multiply with one correction step over the last two stages.
//
// Reset empties the pipeline and loads mean mode with eight frames. When the receiver
// stalls, the result holds and each stage fills its bubble; input stalls only once all
// four stages are full.
module frame_stack_pixel_combine_core #(
    parameter int MAX_FRAMES  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fspc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fspc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f0,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f1,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f2,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f3,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f4,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f5,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f6,
    input  logic [SAMPLE_BITS-1:0]          i_sample_f7,
    input  logic                            i_last_pixel_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [fspc_pkg::OUT_W-1:0]      o_combined_x2,
    output logic                            o_last_pixel_out
);

    localparam int N  = MAX_FRAMES;
    localparam int SW = SAMPLE_BITS;
    localparam int XW = fspc_pkg::f_x_w(N, SW);

    // Configuration registers.
    logic [1:0]                  r_mode;
    logic [fspc_pkg::FRAMES_W-1:0] r_frames;

    // Pipeline valid flags and stage enables.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    logic [SW-1:0]                 w_samples [fspc_pkg::NUM_PORTS];
    logic [fspc_pkg::FRAMES_W-1:0] w_k;
    fspc_pkg::t_side               n_side1;
    fspc_pkg::t_side               r_side1;
    fspc_pkg::t_side               w_side2;

    logic [SW-1:0]               w_value [N];
    logic [fspc_pkg::RANK_W-1:0] w_rank  [N];
    logic                        w_used  [N];
    logic [XW-1:0]               w_x;
    logic [SW:0]                 w_med;

    assign o_cfg_ready = 1'b1;

    // Configuration writes apply directly; user must send them only when idle; unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= fspc_pkg::MODE_MEAN;
            r_frames <= fspc_pkg::FRAMES_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fspc_pkg::REG_COMBINE_MODE:  r_mode   <= i_cfg_data[1:0];
                fspc_pkg::REG_FRAMES_IN_USE: r_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero frame count acts as one; a count above the lane count saturates.
    always_comb begin
        if (r_frames == '0) begin
            w_k = fspc_pkg::FRAMES_W'(1);
        end else if (r_frames > fspc_pkg::FRAMES_W'(N)) begin
            w_k = fspc_pkg::FRAMES_W'(N);
        end else begin
            w_k = r_frames;
        end
        n_side1.frames = w_k;
        n_side1.mode   = r_mode;
        n_side1.last   = i_last_pixel_in;
    end

    assign w_samples[0] = i_sample_f0;
    assign w_samples[1] = i_sample_f1;
    assign w_samples[2] = i_sample_f2;
    assign w_samples[3] = i_sample_f3;
    assign w_samples[4] = i_sample_f4;
    assign w_samples[5] = i_sample_f5;
    assign w_samples[6] = i_sample_f6;
    assign w_samples[7] = i_sample_f7;

    // Each stage advances when it is empty or the stage after it advances.
    assign w_en4      = !r_v4 || i_out_ready;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_side1 <= n_side1;
        end
    end

    // Stage 1: one lane per frame ranks its sample against the other active lanes.
    for (genvar g = 0; g < N; g++) begin : g_lane
        fspc_lane #(
            .N    (N),
            .SW   (SW),
            .LANE (g)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en1),
            .i_samples (w_samples),
            .i_frames  (w_k),
            .o_value   (w_value[g]),
            .o_rank    (w_rank[g]),
            .o_used    (w_used[g])
        );
    end

    // Stage 2: sum and median pick.
    fspc_merge #(
        .N  (N),
        .SW (SW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en2),
        .i_valid (r_v1),
        .i_value (w_value),
        .i_rank  (w_rank),
        .i_used  (w_used),
        .i_side  (r_side1),
        .o_x     (w_x),
        .o_med   (w_med),
        .o_side  (w_side2)
    );

    // Stages 3 and 4: mean, saturation and result register.
    fspc_finish #(
        .N  (N),
        .SW (SW)
    ) u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en3      (w_en3),
        .i_en4      (w_en4),
        .i_s3_valid (r_v3),
        .i_x        (w_x),
        .i_med      (w_med),
        .i_side     (w_side2),
        .o_result   (o_combined_x2),
        .o_last     (o_last_pixel_out)
    );

    assign o_out_valid = r_v4;

`ifndef ASSERT_OFF
    // Input is refused only when every stage holds a pixel and the output stalls.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while pipeline full and stalled");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 || !r_v2 || !r_v3 || !r_v4 || i_out_ready) |-> o_in_ready)
        else $error("input refused while pipeline has room");

    // A stalled result is not replaced by a later pixel.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_out_ready) |=> (r_v4 && $stable(o_combined_x2)))
        else $error("stalled result lost");
`endif

endmodule

[verif/frame_stack_pixel_combine_core_tb.sv]
// Self-checking testbench of the frame stack pixel combiner: directed table, random phases.
`timescale 1ns / 100ps

module frame_stack_pixel_combine_core_tb;

    // The mode register has one code with no name of its own; the block treats it as median.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int LANE_W        = 16;
    localparam int RESET_CYCLES  = 9;
    // Margin after the last result, before a register write or the final verdict.
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int PHASES        = 12;
    localparam int PHASE_PIXELS  = 150;
    localparam int DIRECTED_ROWS = 21;

    typedef logic [fspc_pkg::NUM_PORTS-1:0][LANE_W-1:0] t_lane_set;

    // One row of the directed table. The register values are written before the pixel
    // whenever they differ from the last ones written. Where typed is set, want is the
    // expected combined value; otherwise the predictor supplies it.
    typedef struct packed {
        logic [fspc_pkg::CFG_DATA_W-1:0] mode_cfg;
        logic [fspc_pkg::CFG_DATA_W-1:0] frames_cfg;
        t_lane_set                       lanes;
        logic                            last;
        logic                            typed;
        logic [fspc_pkg::OUT_W-1:0]      want;
    } t_pixel_case;

    typedef struct packed {
        logic [fspc_pkg::OUT_W-1:0] combined_x2;
        logic                       last_pixel;
    } t_pixel_result;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_cfg_valid     = 1'b0;
    logic                            o_cfg_ready;
    logic [fspc_pkg::CFG_IDX_W-1:0]  i_cfg_index     = fspc_pkg::REG_COMBINE_MODE;
    logic [fspc_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                            i_in_valid      = 1'b0;
    logic                            o_in_ready;
    logic [LANE_W-1:0]               i_sample_f0     = '0;
    logic [LANE_W-1:0]               i_sample_f1     = '0;
    logic [LANE_W-1:0]               i_sample_f2     = '0;
    logic [LANE_W-1:0]               i_sample_f3     = '0;
    logic [LANE_W-1:0]               i_sample_f4     = '0;
    logic [LANE_W-1:0]               i_sample_f5     = '0;
    logic [LANE_W-1:0]               i_sample_f6     = '0;
    logic [LANE_W-1:0]               i_sample_f7     = '0;
    logic                            i_last_pixel_in = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready     = 1'b0;
    logic [fspc_pkg::OUT_W-1:0]      o_combined_x2;
    logic                            o_last_pixel_out;

    // Travel with the payload so that the scoreboard knows, at the input transfer,
    // whether a typed value from the directed table stands in for the prediction.
    logic                            case_typed      = 1'b0;
    logic [fspc_pkg::OUT_W-1:0]      case_want       = '0;

    // Knobs shared by the sender, the receiver and the scoreboard.
    bit                              gaps_on         = 1'b1;
    bit                              stalls_on       = 1'b1;
    bit                              hold_request    = 1'b0;
    bit                              hold_done       = 1'b0;
    int                              pixels_accepted = 0;
    int                              results_checked = 0;
    int                              fault_count     = 0;
    t_pixel_result                   expected_pixels[$];

    always #5 i_clk = ~i_clk;

    frame_stack_pixel_combine_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_f0      (i_sample_f0),
        .i_sample_f1      (i_sample_f1),
        .i_sample_f2      (i_sample_f2),
        .i_sample_f3      (i_sample_f3),
        .i_sample_f4      (i_sample_f4),
        .i_sample_f5      (i_sample_f5),
        .i_sample_f6      (i_sample_f6),
        .i_sample_f7      (i_sample_f7),
        .i_last_pixel_in  (i_last_pixel_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_combined_x2    (o_combined_x2),
        .o_last_pixel_out (o_last_pixel_out)
    );

    // Combined value of one pixel, times two. A frame count of zero acts as one and a
    // count above eight acts as eight; lanes at or past the count are ignored. The mean
    // rounds down, and an even median adds the two middle samples instead of halving.
    function automatic logic [fspc_pkg::OUT_W-1:0] predict_combined(
            input t_lane_set lanes, input logic [1:0] mode,
            input logic [fspc_pkg::FRAMES_W-1:0] frames);
        logic [LANE_W-1:0] ranked [fspc_pkg::NUM_PORTS];
        logic [LANE_W-1:0] held;
        logic [22:0]       twice_sum;
        logic [22:0]       result;
        int                k;
        int                i;
        int                j;
        k = (frames == 0) ? 1 : ((frames > fspc_pkg::NUM_PORTS) ? fspc_pkg::NUM_PORTS
                                                                 : int'(frames));
        twice_sum = '0;
        for (i = 0; i < k; i++) begin
            ranked[i] = lanes[i];
            twice_sum += 2 * lanes[i];
        end
        case (mode)
            fspc_pkg::MODE_SUM: begin
                result = twice_sum;
            end
            fspc_pkg::MODE_MEAN: begin
                result = twice_sum / k;
            end
            default: begin
                // Insertion sort of the active lanes, then pick the middle.
                for (i = 1; i < k; i++) begin
                    held = ranked[i];
                    j = i;
                    while (j > 0 && ranked[j-1] > held) begin
                        ranked[j] = ranked[j-1];
                        j--;
                    end
                    ranked[j] = held;
                end
                if (k % 2 == 1) begin
                    result = 2 * ranked[k/2];
                end else begin
                    result = ranked[k/2-1] + ranked[k/2];
                end
            end
        endcase
        if (result > fspc_pkg::OUT_MAX) begin
            result = fspc_pkg::OUT_MAX;
        end
        return result[fspc_pkg::OUT_W-1:0];
    endfunction

    // Scoreboard. It keeps its own copy of the two registers, turns every input transfer
    // into an expectation and checks every result transfer against the oldest one. All
    // signals are read right at the edge, so both sides show their values from before it.
    always @(posedge i_clk) begin : scoreboard
        logic [1:0]                    mode_copy;
        logic [fspc_pkg::FRAMES_W-1:0] frames_copy;
        t_pixel_result                 pending;
        t_pixel_result                 oldest;
        if (!i_rst_n) begin
            mode_copy   = fspc_pkg::MODE_MEAN;
            frames_copy = fspc_pkg::FRAMES_W'(fspc_pkg::NUM_PORTS);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == fspc_pkg::REG_COMBINE_MODE) begin
                    mode_copy = i_cfg_data[1:0];
                end else if (i_cfg_index == fspc_pkg::REG_FRAMES_IN_USE) begin
                    frames_copy = i_cfg_data[fspc_pkg::FRAMES_W-1:0];
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending.combined_x2 = case_typed ? case_want :
                    predict_combined({i_sample_f7, i_sample_f6, i_sample_f5, i_sample_f4,
                                      i_sample_f3, i_sample_f2, i_sample_f1, i_sample_f0},
                                     mode_copy, frames_copy);
                pending.last_pixel  = i_last_pixel_in;
                expected_pixels = {expected_pixels, pending};
                pixels_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result transfer with no pixel outstanding: combined_x2 %0d",
                           o_combined_x2);
                    fault_count++;
                end else begin
                    oldest = expected_pixels.pop_front();
                    results_checked++;
                    if (o_combined_x2 !== oldest.combined_x2) begin
                        $error("combined_x2: expected %0d, got %0d",
                               oldest.combined_x2, o_combined_x2);
                        fault_count++;
                    end
                    if (o_last_pixel_out !== oldest.last_pixel) begin
                        $error("last_pixel_out: expected %0d, got %0d",
                               oldest.last_pixel, o_last_pixel_out);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Receiver. Ready comes in high and low runs of random length.
    // Once the sender asks for it, ready stays low for one long stretch so that the
    // pipeline fills up and pushes back on the input. With stalls off, ready stays high.
    initial begin : result_sink
        logic ready_now;
        int   run;
        forever begin
            if (hold_request && !hold_done) begin
                ready_now = 1'b0;
                run       = LONG_HOLD;
                hold_done = 1'b1;
            end else if (stalls_on && $urandom_range(0, 2) == 0) begin
                ready_now = 1'b0;
                run       = $urandom_range(1, 10);
            end else begin
                ready_now = 1'b1;
                run       = $urandom_range(1, 12);
            end
            repeat (run) begin
                @(posedge i_clk);
                i_out_ready <= ready_now || !stalls_on;
            end
        end
    end

    // Offers one pixel, now and then after a short gap, and returns at the edge of its
    // transfer. Valid is left high so that the next pixel can follow back to back.
    task automatic offer_pixel(input t_lane_set lanes, input logic last,
                               input logic typed, input logic [fspc_pkg::OUT_W-1:0] want);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sample_f0     <= lanes[0];
        i_sample_f1     <= lanes[1];
        i_sample_f2     <= lanes[2];
        i_sample_f3     <= lanes[3];
        i_sample_f4     <= lanes[4];
        i_sample_f5     <= lanes[5];
        i_sample_f6     <= lanes[6];
        i_sample_f7     <= lanes[7];
        i_last_pixel_in <= last;
        case_typed      <= typed;
        case_want       <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops offering and waits until every pixel in flight has come out, plus a margin.
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_checked < pixels_accepted);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers back to back; only called with the pipeline empty.
    task automatic write_registers(input logic [fspc_pkg::CFG_DATA_W-1:0] mode_cfg,
                                   input logic [fspc_pkg::CFG_DATA_W-1:0] frames_cfg);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fspc_pkg::REG_COMBINE_MODE;
        i_cfg_data  <= mode_cfg;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= fspc_pkg::REG_FRAMES_IN_USE;
        i_cfg_data  <= frames_cfg;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_pixel_case                     directed_cases [DIRECTED_ROWS];
        logic [fspc_pkg::CFG_DATA_W-1:0] mode_written;
        logic [fspc_pkg::CFG_DATA_W-1:0] frames_written;
        t_lane_set                       lanes;
        logic                            last;
        int                              style;
        int                              row;
        int                              phase;
        int                              n;
        int                              lane;

        // Lanes are listed from frame seven down to frame zero.
        directed_cases[0]  = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd8, {8{16'h0000}},
                               1'b0, 1'b1, 20'd0};
        directed_cases[1]  = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd8, {8{16'hFFFF}},
                               1'b1, 1'b1, 20'd131070};
        // Upper data bits of the mode write are dropped by the register.
        directed_cases[2]  = '{{2'b11, fspc_pkg::MODE_SUM}, 4'd8, {8{16'hFFFF}},
                               1'b1, 1'b1, 20'd1048560};
        directed_cases[3]  = '{{2'b00, fspc_pkg::MODE_SUM}, 4'd1, {{7{16'h1234}}, 16'hFFFF},
                               1'b0, 1'b1, 20'd131070};
        // A frame count of zero acts as one.
        directed_cases[4]  = '{{2'b00, fspc_pkg::MODE_SUM}, 4'd0, {{7{16'hFFFF}}, 16'd1234},
                               1'b0, 1'b1, 20'd2468};
        // A frame count of fifteen saturates to eight.
        directed_cases[5]  = '{{2'b00, fspc_pkg::MODE_SUM}, 4'd15, {8{16'd1}},
                               1'b0, 1'b1, 20'd16};
        directed_cases[6]  = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd3,
                               {{5{16'hFFFF}}, 16'd0, 16'd1, 16'd1}, 1'b0, 1'b1, 20'd1};
        directed_cases[7]  = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd7,
                               {16'hFFFF, 16'd700, 16'd9, 16'hFFFE, 16'd12345, 16'd3,
                                16'd40000, 16'd1}, 1'b0, 1'b0, 20'd0};
        directed_cases[8]  = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd2,
                               {{6{16'hFFFF}}, 16'd6, 16'd4}, 1'b0, 1'b1, 20'd10};
        directed_cases[9]  = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd6, {8{16'hFFFF}},
                               1'b1, 1'b1, 20'd131070};
        directed_cases[10] = '{{2'b00, fspc_pkg::MODE_MEDIAN}, 4'd5,
                               {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 16'd2, 16'd4, 16'd1, 16'd5},
                               1'b0, 1'b1, 20'd6};
        directed_cases[11] = '{{2'b00, fspc_pkg::MODE_MEDIAN}, 4'd4,
                               {{4{16'd0}}, 16'd30, 16'd20, 16'd40, 16'd10}, 1'b0, 1'b1, 20'd50};
        // The unused mode code acts as median.
        directed_cases[12] = '{{2'b00, MODE_UNUSED}, 4'd8,
                               {16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7},
                               1'b0, 1'b1, 20'd7};
        directed_cases[13] = '{{2'b00, fspc_pkg::MODE_MEDIAN}, 4'd1, {{7{16'd0}}, 16'hFFFF},
                               1'b0, 1'b1, 20'd131070};
        directed_cases[14] = '{{2'b00, fspc_pkg::MODE_MEDIAN}, 4'd2,
                               {{6{16'd0}}, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b1, 20'd131070};
        directed_cases[15] = '{{2'b00, fspc_pkg::MODE_MEDIAN}, 4'd8,
                               {16'd500, 16'hFFFF, 16'd0, 16'd32768, 16'd17, 16'd32767,
                                16'd65000, 16'd2}, 1'b1, 1'b0, 20'd0};
        directed_cases[16] = '{{2'b00, fspc_pkg::MODE_MEDIAN}, 4'd3,
                               {{5{16'hFFFF}}, 16'd2, 16'd9, 16'd9}, 1'b0, 1'b1, 20'd18};
        directed_cases[17] = '{{2'b10, fspc_pkg::MODE_MEDIAN}, 4'd15,
                               {16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                                16'd1}, 1'b0, 1'b0, 20'd0};
        directed_cases[18] = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd8, {4{16'hAAAA, 16'h5555}},
                               1'b1, 1'b0, 20'd0};
        directed_cases[19] = '{{2'b00, fspc_pkg::MODE_SUM}, 4'd8, {4{16'h5555, 16'hAAAA}},
                               1'b0, 1'b0, 20'd0};
        directed_cases[20] = '{{2'b00, fspc_pkg::MODE_MEAN}, 4'd5, {8{16'hFFFF}},
                               1'b0, 1'b1, 20'd131070};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. The first rows run on the values loaded by reset.
        mode_written   = {2'b00, fspc_pkg::MODE_MEAN};
        frames_written = fspc_pkg::CFG_DATA_W'(fspc_pkg::NUM_PORTS);
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_cases[row].mode_cfg != mode_written ||
                directed_cases[row].frames_cfg != frames_written) begin
                settle_pipeline();
                write_registers(directed_cases[row].mode_cfg, directed_cases[row].frames_cfg);
                mode_written   = directed_cases[row].mode_cfg;
                frames_written = directed_cases[row].frames_cfg;
            end
            offer_pixel(directed_cases[row].lanes, directed_cases[row].last,
                        directed_cases[row].typed, directed_cases[row].want);
        end

        // Random phases, each with its own register setting. The first four walk all
        // mode codes; the rest draw both registers over their full data range. The last
        // phase runs with no gaps and no stalls at all.
        for (phase = 0; phase < PHASES; phase++) begin
            settle_pipeline();
            if (phase == PHASES - 1) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if (phase < 4) begin
                write_registers(fspc_pkg::CFG_DATA_W'(phase),
                                fspc_pkg::CFG_DATA_W'($urandom_range(1, fspc_pkg::NUM_PORTS)));
            end else begin
                write_registers(fspc_pkg::CFG_DATA_W'($urandom_range(0, 15)),
                                fspc_pkg::CFG_DATA_W'($urandom_range(0, 15)));
            end
            // Ask the receiver for its long hold-off while pixels keep coming.
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            for (n = 0; n < PHASE_PIXELS; n++) begin
                // The sender also pauses once in the middle of a phase until it drains.
                if (phase == 5 && n == PHASE_PIXELS / 2) begin
                    settle_pipeline();
                end
                // A whole pixel shares one style: full range, extremes only, a few small
                // values that force ties in the median, or values just under the top.
                style = $urandom_range(0, 3);
                for (lane = 0; lane < fspc_pkg::NUM_PORTS; lane++) begin
                    case (style)
                        0:       lanes[lane] = LANE_W'($urandom);
                        1:       lanes[lane] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        2:       lanes[lane] = LANE_W'($urandom_range(0, 7));
                        default: lanes[lane] = 16'hFFF8 + LANE_W'($urandom_range(0, 7));
                    endcase
                end
                last = ($urandom_range(0, 15) == 0);
                offer_pixel(lanes, last, 1'b0, '0);
            end
        end

        settle_pipeline();
        if (expected_pixels.size() != 0) begin
            $error("%0d expected results never arrived", expected_pixels.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: the slowest correct run needs well under a tenth of this.
    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hw/rtl/fspc_pkg.sv
hw/rtl/fspc_lane.sv
hw/rtl/fspc_merge.sv
hw/rtl/fspc_finish.sv
hw/rtl/frame_stack_pixel_combine_core.sv
verif/frame_stack_pixel_combine_core_tb.sv
